/* hdl/ssra_pkg.sv */
// Package for the sensor send, acknowledge and retry engine.
// Holds operation codes, reply codes, field widths and the result record type.
// Depends on nothing; imported by sensor_send_retry_ack.
`default_nettype none

package ssra_pkg;

   localparam int VALUE_WIDTH = 24;
   localparam int WORD_W      = 24;

   localparam logic [WORD_W-1:0] VALUE_MASK =
      (VALUE_WIDTH >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << VALUE_WIDTH) - 64'd1);

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_START_DATA = 3'd1,
      OP_START_PAIR = 3'd2,
      OP_PACKET     = 3'd3,
      OP_STATUS     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_SENSOR_ID   = 2'd0,
      CSR_RETRY_LIMIT = 2'd1,
      CSR_ACK_TIMEOUT = 2'd2
   } csr_index_type;

   localparam logic [7:0] RX_DATA_REPLY = 8'h80;
   localparam logic [7:0] RX_PAIR_REPLY = 8'h81;
   localparam logic [1:0] TYPE_GEN      = 2'd1;
   localparam logic [1:0] TYPE_CON      = 2'd2;

   localparam logic [1:0] LED_NONE  = 2'd0;
   localparam logic [1:0] LED_SHORT = 2'd1;
   localparam logic [1:0] LED_PAIR  = 2'd2;

   localparam logic [7:0] SENSOR_ID_RESET   = 8'd1;
   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd100;

   typedef struct packed {
      logic              send;
      logic [7:0]        send_dest_id;
      logic [1:0]        send_source_type;
      logic              send_op;
      logic [WORD_W-1:0] send_value;
      logic [WORD_W-1:0] send_battery;
      logic              go_sleep;
      logic              save_base;
      logic [1:0]        led_request;
      logic              radio_idle;
      logic [7:0]        base_now;
      logic [1:0]        status_now;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/sensor_send_retry_ack.sv */
// Send, acknowledge and retry engine of a sensor radio node: event decoding,
// retry state and a two-word output buffer. Uses ssra_pkg.
//
// Usage: each word on the req_ channel is one event (tick, start data report,
// start pairing, received packet, status query) and yields exactly one word on
// the rsp_ channel. The event is decoded and the node state updated in the
// cycle it is accepted; the result word is registered and offered on rsp_;
// throughput is one word per cycle while the receiver takes each word. A
// second result register catches one more word while the
// receiver stalls; req_tready drops only when both registers are full, and
// rises again as soon as the receiver takes a word.
// Configuration writes through csr_ take effect at the clock edge of the
// write and must only be made while the block is idle.
// Reset (synchronous, active high) clears pairing mode, paired flag, base
// identity, send count, timer and the latched words, empties both result
// registers and loads the register defaults: sensor identity 1, retry limit
// 5, acknowledge timeout 100 ticks.
`default_nettype none

module sensor_send_retry_ack
   import ssra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // jumper_generator, current_value, battery_value, rx_dest_id, rx_source_id,
   // rx_op, zero padding
   input  wire logic [79:0] req_tdata,
   // operation
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // send_dest_id, send_source_type, send_op, send_value, send_battery,
   // go_sleep, save_base, led_request, radio_idle, base_now, status_now,
   // zero padding
   output logic [79:0]      rsp_tdata,
   // send
   output logic             rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0]        sensor_id_ff;
   logic [3:0]        retry_limit_ff;
   logic [7:0]        ack_timeout_ff;

   logic              pairing_mode_ff, pairing_mode_in;
   logic              paired_ff, paired_in;
   logic [7:0]        base_identity_ff, base_identity_in;
   logic [3:0]        send_count_ff, send_count_in;
   logic [7:0]        ack_timer_ff, ack_timer_in;
   logic [WORD_W-1:0] held_current_ff, held_current_in;
   logic [WORD_W-1:0] held_battery_ff, held_battery_in;

   rsp_type           out_ff, skid_ff, res_in;
   logic              out_valid_ff, skid_valid_ff;

   logic              accept, take;

   logic              in_jumper;
   logic [WORD_W-1:0] in_current, in_battery;
   logic [7:0]        in_dest, in_source, in_rop;
   op_type            in_op;

   assign in_op      = op_type'(req_tuser);
   assign in_jumper  = req_tdata[0];
   assign in_current = req_tdata[24:1];
   assign in_battery = req_tdata[48:25];
   assign in_dest    = req_tdata[56:49];
   assign in_source  = req_tdata[64:57];
   assign in_rop     = req_tdata[72:65];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   always_comb begin
      logic       do_data;
      logic       do_pair;
      logic [7:0] timer_dec;
      logic [1:0] src_type;

      do_data   = 1'b0;
      do_pair   = 1'b0;
      timer_dec = ack_timer_ff - 8'd1;
      src_type  = in_jumper ? TYPE_GEN : TYPE_CON;

      pairing_mode_in  = pairing_mode_ff;
      paired_in        = paired_ff;
      base_identity_in = base_identity_ff;
      send_count_in    = send_count_ff;
      ack_timer_in     = ack_timer_ff;
      held_current_in  = held_current_ff;
      held_battery_in  = held_battery_ff;
      res_in           = '0;

      case (in_op)
         OP_TICK: begin
            if (ack_timer_ff != 8'd0) begin
               ack_timer_in = timer_dec;
               if (timer_dec == 8'd0) begin
                  do_pair = pairing_mode_ff;
                  do_data = !pairing_mode_ff;
               end
            end
         end
         OP_START_DATA: begin
            held_current_in = in_current & VALUE_MASK;
            held_battery_in = in_battery & VALUE_MASK;
            send_count_in   = 4'd0;
            do_data         = 1'b1;
         end
         OP_START_PAIR: begin
            pairing_mode_in = 1'b1;
            send_count_in   = 4'd0;
            do_pair         = 1'b1;
         end
         OP_PACKET: begin
            if (pairing_mode_ff) begin
               if (in_rop == RX_PAIR_REPLY && in_dest == sensor_id_ff) begin
                  base_identity_in   = in_source;
                  paired_in          = 1'b1;
                  pairing_mode_in    = 1'b0;
                  ack_timer_in       = 8'd0;
                  res_in.save_base   = 1'b1;
                  res_in.led_request = LED_PAIR;
                  res_in.go_sleep    = 1'b1;
               end
            end else begin
               if (in_rop == RX_DATA_REPLY && in_dest == sensor_id_ff &&
                   in_source == base_identity_ff) begin
                  ack_timer_in      = 8'd0;
                  res_in.radio_idle = 1'b1;
                  res_in.go_sleep   = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_data && !pairing_mode_in) begin
         if (send_count_in < retry_limit_ff && paired_ff) begin
            res_in.send             = 1'b1;
            res_in.send_dest_id     = base_identity_ff;
            res_in.send_source_type = src_type;
            res_in.send_op          = 1'b0;
            res_in.send_value       = held_current_in;
            res_in.send_battery     = held_battery_in;
            res_in.led_request      = LED_SHORT;
            send_count_in           = send_count_in + 4'd1;
            ack_timer_in            = ack_timeout_ff;
         end else begin
            res_in.go_sleep = 1'b1;
         end
      end

      if (do_pair) begin
         if (send_count_in < retry_limit_ff) begin
            res_in.send             = 1'b1;
            res_in.send_dest_id     = 8'd0;
            res_in.send_source_type = src_type;
            res_in.send_op          = 1'b1;
            send_count_in           = send_count_in + 4'd1;
            ack_timer_in            = ack_timeout_ff;
         end else begin
            pairing_mode_in = 1'b0;
            res_in.go_sleep = 1'b1;
         end
      end

      res_in.base_now   = base_identity_in;
      res_in.status_now = {paired_in, pairing_mode_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff     <= SENSOR_ID_RESET;
         retry_limit_ff   <= RETRY_LIMIT_RESET;
         ack_timeout_ff   <= ACK_TIMEOUT_RESET;
         pairing_mode_ff  <= 1'b0;
         paired_ff        <= 1'b0;
         base_identity_ff <= 8'd0;
         send_count_ff    <= 4'd0;
         ack_timer_ff     <= 8'd0;
         held_current_ff  <= '0;
         held_battery_ff  <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SENSOR_ID:   sensor_id_ff   <= csr_wdata;
               CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[3:0];
               CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (accept) begin
            pairing_mode_ff  <= pairing_mode_in;
            paired_ff        <= paired_in;
            base_identity_ff <= base_identity_in;
            send_count_ff    <= send_count_in;
            ack_timer_ff     <= ack_timer_in;
            held_current_ff  <= held_current_in;
            held_battery_ff  <= held_battery_in;
         end

         if (take && skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept && (!out_valid_ff || take)) begin
            out_ff       <= res_in;
            out_valid_ff <= 1'b1;
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end

         if (accept && out_valid_ff && !take) begin
            skid_ff       <= res_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.send;
   assign rsp_tdata  = {6'd0,
                        out_ff.status_now,
                        out_ff.base_now,
                        out_ff.radio_idle,
                        out_ff.led_request,
                        out_ff.save_base,
                        out_ff.go_sleep,
                        out_ff.send_battery,
                        out_ff.send_value,
                        out_ff.send_op,
                        out_ff.send_source_type,
                        out_ff.send_dest_id};

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_pair_req_broadcast: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.send && out_ff.send_op) |-> (out_ff.send_dest_id == 8'd0))
      else $error("pairing request not sent as broadcast");

   a_send_not_sleep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.send && out_ff.go_sleep))
      else $error("send and sleep requested together");

   a_save_sets_paired: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.save_base) |-> (out_ff.status_now == 2'b10))
      else $error("base saved without paired status");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(send_count_ff) && $stable(ack_timer_ff))
      else $error("retry state changed without an accepted word");
`endif

endmodule

`default_nettype wire
